@@ hw/rtl/sobel_pkg.sv @@
// shared constants and types of the sobel edge magnitude block
package sobel_pkg;

  // line buffer geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);

  // frame height limit and row counter widths
  localparam int ROW_LIMIT = 1024;
  localparam int ROW_CNT_W = $clog2(ROW_LIMIT + 1);

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 10;
  localparam int OUT_COL_W = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // widths used when saturating register values
  localparam int WSAT_W = (COL_W > CFG_W) ? COL_W : CFG_W;
  localparam int HSAT_W = (ROW_CNT_W > CFG_W) ? ROW_CNT_W : CFG_W;

  // register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // position and classification of one pixel
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] col;
    logic              interior;
    logic              border;
  } pos_t;

  // one result item
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic [PIX_W-1:0]     value;
    logic                 last;
  } res_t;

endpackage

@@ hw/rtl/sobel_line_ram.sv @@
// simple dual port synchronous ram, registered read
module sobel_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/sobel_pos.sv @@
// frame size registers and raster position tracking
module sobel_pos (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            accept,
  output sobel_pkg::pos_t                 pos
);
  import sobel_pkg::*;

  logic [CFG_W-1:0]     image_width;
  logic [CFG_W-1:0]     image_height;
  logic [COL_W-1:0]     col_count;
  logic [ROW_CNT_W-1:0] row_count;

  logic [WSAT_W-1:0]    w_ext;
  logic [HSAT_W-1:0]    h_ext;
  logic [COL_W-1:0]     w_eff;
  logic [ROW_CNT_W-1:0] h_eff;
  logic                 col_wrap;
  logic [COL_W-1:0]     c;
  logic [ROW_CNT_W-1:0] r_inc;
  logic [ROW_CNT_W-1:0] r;
  logic [COL_W-1:0]     c_plus;
  logic                 row_end;
  logic [ROW_CNT_W-1:0] r_adv;
  logic [COL_W-1:0]     col_count_next;
  logic [ROW_CNT_W-1:0] row_count_next;

  // width and height saturated to their legal ranges
  assign w_ext = WSAT_W'(image_width);
  assign h_ext = HSAT_W'(image_height);
  assign w_eff = (w_ext == '0) ? COL_W'(1) :
                 (w_ext > WSAT_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : COL_W'(w_ext);
  assign h_eff = (h_ext == '0) ? ROW_CNT_W'(1) :
                 (h_ext > HSAT_W'(ROW_LIMIT)) ? ROW_CNT_W'(ROW_LIMIT) : ROW_CNT_W'(h_ext);

  // position of this pixel, folded against the current frame size
  assign col_wrap = col_count >= w_eff;
  assign c        = col_wrap ? '0 : col_count;
  assign r_inc    = col_wrap ? row_count + ROW_CNT_W'(1) : row_count;
  assign r        = (r_inc >= h_eff) ? '0 : r_inc;

  // position of the following pixel
  assign c_plus         = c + COL_W'(1);
  assign row_end        = c_plus >= w_eff;
  assign r_adv          = row_end ? r + ROW_CNT_W'(1) : r;
  assign col_count_next = row_end ? '0 : c_plus;
  assign row_count_next = (r_adv >= h_eff) ? '0 : r_adv;

  assign pos.row      = ROW_W'(r);
  assign pos.col      = ADDR_W'(c);
  assign pos.interior = (r >= ROW_CNT_W'(2)) && (c >= COL_W'(2));
  assign pos.border   = (r == '0) || (r == h_eff - ROW_CNT_W'(1)) ||
                        (c == '0) || (c == w_eff - COL_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

@@ hw/rtl/sobel_grad.sv @@
// window stage: line buffer read-back, forwarding, sobel kernels, result sequencing
module sobel_grad (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  sobel_pkg::pos_t              pos_in,
  input  logic [sobel_pkg::PIX_W-1:0]  pix_in,
  input  logic [2*sobel_pkg::PIX_W-1:0] ram_rd_data,
  output logic                         ram_wr_en,
  output logic [sobel_pkg::ADDR_W-1:0] ram_wr_addr,
  output logic [2*sobel_pkg::PIX_W-1:0] ram_wr_data,
  output logic                         busy,
  output logic                         res_valid,
  output sobel_pkg::res_t              res,
  input  logic                         res_ready
);
  import sobel_pkg::*;

  localparam int SUM_W = PIX_W + 2;
  localparam int G_W   = PIX_W + 4;

  logic             b_valid;
  pos_t             b_pos;
  logic [PIX_W-1:0] b_pix;
  logic             b_fwd;
  logic [PIX_W-1:0] b_fwd_top;
  logic [PIX_W-1:0] b_fwd_mid;
  logic             phase;
  logic [PIX_W-1:0] win [6];

  logic [PIX_W-1:0] top_eff;
  logic [PIX_W-1:0] mid_eff;
  logic [SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [G_W-1:0]   gx, gy, gx_abs, gy_abs, mag;
  logic             emit_int;
  logic             leave;

  // ram word: upper line in the high byte, middle line in the low byte
  assign top_eff = b_fwd ? b_fwd_top : ram_rd_data[2*PIX_W-1:PIX_W];
  assign mid_eff = b_fwd ? b_fwd_mid : ram_rd_data[PIX_W-1:0];

  // kernels: window holds nw, w, sw, n, -, s; the new column is ne, e, se
  assign gx_pos = SUM_W'(top_eff) + {1'b0, mid_eff, 1'b0} + SUM_W'(b_pix);
  assign gx_neg = SUM_W'(win[0]) + {1'b0, win[1], 1'b0} + SUM_W'(win[2]);
  assign gy_pos = SUM_W'(win[0]) + {1'b0, win[3], 1'b0} + SUM_W'(top_eff);
  assign gy_neg = SUM_W'(win[2]) + {1'b0, win[5], 1'b0} + SUM_W'(b_pix);
  assign gx     = G_W'(gx_pos) - G_W'(gx_neg);
  assign gy     = G_W'(gy_pos) - G_W'(gy_neg);
  assign gx_abs = gx[G_W-1] ? -gx : gx;
  assign gy_abs = gy[G_W-1] ? -gy : gy;
  assign mag    = gx_abs + gy_abs;

  // interior result first, border pass-through second
  assign emit_int  = b_pos.interior && !phase;
  assign res_valid = b_valid && (emit_int || b_pos.border);
  always_comb begin
    if (emit_int) begin
      res.row   = b_pos.row - ROW_W'(1);
      res.col   = OUT_COL_W'(b_pos.col - ADDR_W'(1));
      res.value = mag[PIX_W:1];
      res.last  = !b_pos.border;
    end else begin
      res.row   = b_pos.row;
      res.col   = OUT_COL_W'(b_pos.col);
      res.value = b_pix;
      res.last  = 1'b1;
    end
  end

  assign leave = b_valid && (!res_valid || (res_ready && res.last));
  assign busy  = b_valid && !leave;

  // write-back when the pixel leaves the stage
  assign ram_wr_en   = leave;
  assign ram_wr_addr = b_pos.col;
  assign ram_wr_data = {mid_eff, b_pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      phase   <= 1'b0;
    end else begin
      if (load) begin
        b_valid <= 1'b1;
      end else if (leave) begin
        b_valid <= 1'b0;
      end
      if (leave) begin
        phase <= 1'b0;
      end else if (res_valid && res_ready) begin
        phase <= 1'b1;
      end
    end
  end

  // payload; forward the write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (load) begin
      b_pos     <= pos_in;
      b_pix     <= pix_in;
      b_fwd     <= leave && (b_pos.col == pos_in.col);
      b_fwd_top <= mid_eff;
      b_fwd_mid <= b_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (leave) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_eff;
      win[4] <= mid_eff;
      win[5] <= b_pix;
    end
  end

endmodule

@@ hw/rtl/sobel_edge_magnitude_3x3_top.sv @@
// top level of the streaming 3x3 sobel edge magnitude block
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  pixel in  | in_valid / in_stall  | pixel_value
//  result    | out_valid / out_stall| out_row, out_col, edge_value, run_last
//  config    | cfg_write            | cfg_index, cfg_data
//
//  one pixel transfer per clock while in_stall is low; a pixel's result passes the
//  window stage into the result register. a pixel on the bottom row or right column
//  of an interior position yields two results, and the window stage then holds off
//  the next input until the second is taken. rst clears position, window and frame
//  size (640 x 480); the line ram has no reset and is filled by the first two rows.
//  out_stall reaches in_stall through the window stage in the same cycle.
module sobel_edge_magnitude_3x3_top (
  input  logic                             clk,
  input  logic                             rst,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sobel_pkg::PIX_W-1:0]      pixel_value,
  // results
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sobel_pkg::ROW_W-1:0]      out_row,
  output logic [sobel_pkg::OUT_COL_W-1:0]  out_col,
  output logic [sobel_pkg::PIX_W-1:0]      edge_value,
  output logic                             run_last,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobel_pkg::CFG_W-1:0]      cfg_data
);
  import sobel_pkg::*;

  logic                  in_accept;
  pos_t                  pos;
  logic                  grad_busy;
  logic [2*PIX_W-1:0]    ram_rd_data;
  logic                  ram_wr_en;
  logic [ADDR_W-1:0]     ram_wr_addr;
  logic [2*PIX_W-1:0]    ram_wr_data;
  logic                  res_valid;
  res_t                  res;
  logic                  res_ready;

  // input transfer happens whenever the window stage is free or emptying
  assign in_stall  = grad_busy;
  assign in_accept = in_valid && !in_stall;

  // raster position and frame size registers
  sobel_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_accept),
    .pos       (pos)
  );

  // both line buffers share one word per column: upper row high, middle row low
  sobel_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (2 * PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (pos.col),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  // window, kernels and result ordering
  sobel_grad u_grad (
    .clk         (clk),
    .rst         (rst),
    .load        (in_accept),
    .pos_in      (pos),
    .pix_in      (pixel_value),
    .ram_rd_data (ram_rd_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .busy        (grad_busy),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  // output register: refills in the cycle its current result is transferred
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_row    <= res.row;
      out_col    <= res.col;
      edge_value <= res.value;
      run_last   <= res.last;
    end
  end

endmodule

@@ sim/tb_sobel_edge_magnitude_3x3_top.sv @@
// testbench for the streaming 3x3 sobel edge magnitude block: directed rows, then random frames
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_3x3_top;
  import sobel_pkg::*;

  // predictor-checked row marker, settle time before a register write, idle odds, run limit
  localparam int USE_MODEL     = -1;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PCT      = 6;
  localparam int TIMEOUT_NS    = 1000000;

  // frame size of the stretch with no idling
  localparam int CALM_WIDTH  = 32;
  localparam int CALM_HEIGHT = 4;

  typedef enum bit {STEP_PIXEL, STEP_WRITE} step_kind_t;

  // one row of the directed stimulus: a pixel transfer or a register write
  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    logic [PIX_W-1:0]     pix;
    int                   n_typed;
    res_t                 t0;
    res_t                 t1;
  } dir_row_t;

  // block ports, all inputs known from time zero
  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel_value = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic [PIX_W-1:0]     edge_value;
  logic                 run_last;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;

  // predictor state: two line stores, a two-column window, position and frame size
  logic [PIX_W-1:0] above2_line [MAX_WIDTH];
  logic [PIX_W-1:0] above1_line [MAX_WIDTH];
  logic [PIX_W-1:0] win_px [6];
  int               pos_row;
  int               pos_col;
  logic [CFG_W-1:0] reg_width  = WIDTH_RESET;
  logic [CFG_W-1:0] reg_height = HEIGHT_RESET;

  // results still owed by the block, oldest first
  res_t     pending_results [$];
  dir_row_t directed_rows [$];

  int mismatches;
  int results_checked;
  int gradients_seen;
  int pixels_sent;
  int writes_done;
  int small_sent;
  bit calm;

  sobel_edge_magnitude_3x3_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_value(pixel_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .edge_value (edge_value),
    .run_last   (run_last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // saturate a register value into 1..hi
  function automatic int clamp_dim(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // end of row moves to column 0 of the next row, past the bottom back to row 0
  function automatic void wrap_pos(inout int r, inout int c, input int w, input int h);
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
  endfunction

  // true when the next pixel would open a fresh frame under the current size
  function automatic bit at_frame_start();
    int r = pos_row;
    int c = pos_col;
    wrap_pos(r, c, clamp_dim(int'(reg_width), MAX_WIDTH), clamp_dim(int'(reg_height), ROW_LIMIT));
    return (r == 0) && (c == 0);
  endfunction

  // mostly full-range grey, a quarter black or white to drive large gradients
  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(99, 0) < 25)
      return ($urandom_range(1, 0) != 0) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
    return PIX_W'($urandom_range(255, 0));
  endfunction

  function automatic void add_pixel(input logic [PIX_W-1:0] p, input int n,
                                    input int r0, input int c0, input int v0,
                                    input int r1, input int c1, input int v1);
    dir_row_t d;
    d          = '0;
    d.kind     = STEP_PIXEL;
    d.pix      = p;
    d.n_typed  = n;
    d.t0.row   = ROW_W'(r0);
    d.t0.col   = OUT_COL_W'(c0);
    d.t0.value = PIX_W'(v0);
    d.t0.last  = (n == 1);
    d.t1.row   = ROW_W'(r1);
    d.t1.col   = OUT_COL_W'(c1);
    d.t1.value = PIX_W'(v1);
    d.t1.last  = 1'b1;
    directed_rows.push_back(d);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int v);
    dir_row_t d;
    d      = '0;
    d.kind = STEP_WRITE;
    d.idx  = idx;
    d.val  = CFG_W'(v);
    directed_rows.push_back(d);
  endfunction

  // sobel result for one incoming pixel: interior result first, border pass-through second
  task automatic predict_pixel(input logic [PIX_W-1:0] p, output res_t first,
                               output res_t second, output int n);
    int               w, h, gx, gy;
    logic [PIX_W-1:0] top, mid;
    res_t             border_res;
    w = clamp_dim(int'(reg_width), MAX_WIDTH);
    h = clamp_dim(int'(reg_height), ROW_LIMIT);
    wrap_pos(pos_row, pos_col, w, h);
    top    = above2_line[pos_col];
    mid    = above1_line[pos_col];
    first  = '0;
    second = '0;
    n      = 0;
    // full window available: emit the pixel one row up and one column left
    if (pos_row >= 2 && pos_col >= 2) begin
      gx = mag(int'(top) + 2 * int'(mid) + int'(p)
               - int'(win_px[0]) - 2 * int'(win_px[1]) - int'(win_px[2]));
      gy = mag(int'(win_px[0]) + 2 * int'(win_px[3]) + int'(top)
               - int'(win_px[2]) - 2 * int'(win_px[5]) - int'(p));
      first.row   = ROW_W'(pos_row - 1);
      first.col   = OUT_COL_W'(pos_col - 1);
      first.value = PIX_W'((gx + gy) >> 1);
      n = 1;
      gradients_seen++;
    end
    if (pos_row == 0 || pos_row == h - 1 || pos_col == 0 || pos_col == w - 1) begin
      border_res       = '0;
      border_res.row   = ROW_W'(pos_row);
      border_res.col   = OUT_COL_W'(pos_col);
      border_res.value = p;
      if (n == 0) first = border_res;
      else second = border_res;
      n++;
    end
    if (n == 1) first.last = 1'b1;
    else if (n == 2) second.last = 1'b1;
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = top;
    win_px[4] = mid;
    win_px[5] = p;
    above2_line[pos_col] = mid;
    above1_line[pos_col] = p;
    pos_col++;
    wrap_pos(pos_row, pos_col, w, h);
  endtask

  // one pixel transfer; typed rows replace the predicted results with their own
  task automatic push_pixel(input logic [PIX_W-1:0] p, input int n_typed,
                            input res_t t0, input res_t t1);
    res_t m0, m1;
    int   n;
    while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= p;
    do @(posedge clk); while (in_stall);
    predict_pixel(p, m0, m1, n);
    pixels_sent++;
    if (n_typed != USE_MODEL) begin
      n  = n_typed;
      m0 = t0;
      m1 = t1;
    end
    if (n > 0) pending_results.push_back(m0);
    if (n > 1) pending_results.push_back(m1);
  endtask

  task automatic send_random(input int count);
    repeat (count) push_pixel(rand_pixel(), USE_MODEL, '0, '0);
  endtask

  task automatic finish_frame();
    while (!at_frame_start()) push_pixel(rand_pixel(), USE_MODEL, '0, '0);
  endtask

  // drop valid, let every owed result arrive, then cover pixels that owe nothing
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // single register write; cfg_write is dropped again before the task returns
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) reg_width = val;
    else reg_height = val;
    writes_done++;
    @(posedge clk);
  endtask

  // small random frames; a quarter of them get cut by a mid-frame size change
  task automatic run_small_phases(input int target);
    int w_val, h_val, ew, eh, frames, start;
    while (small_sent < target) begin
      start = pixels_sent;
      w_val = ($urandom_range(99, 0) < 85) ? $urandom_range(12, 3) : $urandom_range(2, 0);
      h_val = ($urandom_range(99, 0) < 85) ? $urandom_range(8, 3) : $urandom_range(2, 0);
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, CFG_W'(w_val));
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_val));
      ew     = clamp_dim(w_val, MAX_WIDTH);
      eh     = clamp_dim(h_val, ROW_LIMIT);
      frames = $urandom_range(2, 1);
      if ($urandom_range(99, 0) < 25) begin
        send_random($urandom_range(ew * eh, 1));
        wait_drained();
        // width only ever narrows mid-frame, so the line stores stay filled
        if ($urandom_range(1, 0) != 0)
          write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(ew, 0)));
        else
          write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(10, 0)));
        finish_frame();
      end else begin
        send_random(frames * ew * eh);
      end
      small_sent += pixels_sent - start;
    end
  endtask

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // result side: compare every transfer with the oldest owed result, stall at random
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result at row %0d col %0d", out_row, out_col));
        end else begin
          want = pending_results.pop_front();
          if (out_row !== want.row)
            note_mismatch($sformatf("out_row got %0d want %0d", out_row, want.row));
          if (out_col !== want.col)
            note_mismatch($sformatf("out_col got %0d want %0d", out_col, want.col));
          if (edge_value !== want.value)
            note_mismatch($sformatf("edge_value got %0d want %0d at (%0d,%0d)",
                                    edge_value, want.value, want.row, want.col));
          if (run_last !== want.last)
            note_mismatch($sformatf("run_last got %b want %b at (%0d,%0d)",
                                    run_last, want.last, want.row, want.col));
          results_checked++;
        end
      end
      out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    dir_row_t row;
    foreach (above2_line[i]) above2_line[i] = '0;
    foreach (above1_line[i]) above1_line[i] = '0;
    foreach (win_px[i]) win_px[i] = '0;
    pos_row = 0;
    pos_col = 0;
    calm    = 1'b0;

    // reset size 640 x 480: the first row passes straight through
    add_pixel(8'h00, 1, 0, 0, 8'h00, 0, 0, 0);
    add_pixel(8'hFF, 1, 0, 1, 8'hFF, 0, 0, 0);
    // narrowing below the current column closes the row at once
    add_write(REG_IMAGE_WIDTH, 2);
    add_pixel(8'h5A, 1, 1, 0, 8'h5A, 0, 0, 0);
    add_pixel(8'hA5, 1, 1, 1, 8'hA5, 0, 0, 0);
    // height shrunk mid-frame, row 2 now the bottom row
    add_write(REG_IMAGE_HEIGHT, 3);
    add_pixel(8'h01, 1, 2, 0, 8'h01, 0, 0, 0);
    add_pixel(8'h80, 1, 2, 1, 8'h80, 0, 0, 0);
    // smallest frame with an interior pixel; its magnitude 1020, halved to 510, wraps to 254
    add_write(REG_IMAGE_WIDTH, 3);
    add_pixel(8'd0,   1, 0, 0, 0,   0, 0, 0);
    add_pixel(8'd128, 1, 0, 1, 128, 0, 0, 0);
    add_pixel(8'd255, 1, 0, 2, 255, 0, 0, 0);
    add_pixel(8'd0,   1, 1, 0, 0,   0, 0, 0);
    add_pixel(8'd77,  0, 0, 0, 0,   0, 0, 0);
    add_pixel(8'd255, 1, 1, 2, 255, 0, 0, 0);
    add_pixel(8'd0,   1, 2, 0, 0,   0, 0, 0);
    add_pixel(8'd128, 1, 2, 1, 128, 0, 0, 0);
    add_pixel(8'd255, 2, 1, 1, 254, 2, 2, 255);
    // zero size saturates to 1 x 1: every pixel is its own frame
    add_write(REG_IMAGE_WIDTH, 0);
    add_write(REG_IMAGE_HEIGHT, 0);
    add_pixel(8'h3C, 1, 0, 0, 8'h3C, 0, 0, 0);
    add_pixel(8'hC3, 1, 0, 0, 8'hC3, 0, 0, 0);
    // all-ones size saturates to the 1024 limits
    add_write(REG_IMAGE_WIDTH, 2047);
    add_write(REG_IMAGE_HEIGHT, 2047);
    add_pixel(8'h11, 1, 0, 0, 8'h11, 0, 0, 0);
    add_pixel(8'h22, USE_MODEL, 0, 0, 0, 0, 0, 0);
    add_pixel(8'h33, USE_MODEL, 0, 0, 0, 0, 0, 0);
    add_write(REG_IMAGE_WIDTH, 3);
    add_pixel(8'h44, 1, 1, 0, 8'h44, 0, 0, 0);
    // height below the current row ends the frame at once
    add_write(REG_IMAGE_HEIGHT, 1);
    add_pixel(8'h55, 1, 0, 1, 8'h55, 0, 0, 0);
    add_pixel(8'h66, USE_MODEL, 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, register writes only once the block has drained
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == STEP_WRITE) begin
        wait_drained();
        write_reg(row.idx, row.val);
      end else begin
        push_pixel(row.pix, row.n_typed, row.t0, row.t1);
      end
    end
    finish_frame();

    run_small_phases(150);

    // one whole frame with no idling on either side
    calm = 1'b1;
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(CALM_WIDTH));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(CALM_HEIGHT));
    send_random(CALM_WIDTH * CALM_HEIGHT);
    calm = 1'b0;

    run_small_phases(250);

    // narrow rows under a saturated height
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(3));
    write_reg(REG_IMAGE_HEIGHT, {CFG_W{1'b1}});
    send_random(24);

    wait_drained();
    $display("covered %0d pixel transfers and %0d register writes, sizes 1x1 to saturated",
             pixels_sent, writes_done);
    $display("compared %0d results, %0d of them gradient values, %0d mismatches",
             results_checked, gradients_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop should the block hang
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("no end of run after %0d ns", TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sobel_pkg.sv
hw/rtl/sobel_line_ram.sv
hw/rtl/sobel_pos.sv
hw/rtl/sobel_grad.sv
hw/rtl/sobel_edge_magnitude_3x3_top.sv
sim/tb_sobel_edge_magnitude_3x3_top.sv
